### sv/midi_voice_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// MIDI voice allocator assertion macros
// Shared assertion helpers, clocked on clk_i and quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MIDI_VOICE_ALLOCATOR_TOP_DEFINES_SVH
`define MIDI_VOICE_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define MVA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MVA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mva_pkg.sv
// ----------------------------------------------------------------------------
// MIDI voice allocator package
// Field widths, the control bundle for the voice table and the pitch ROM.
// ----------------------------------------------------------------------------
package mva_pkg;

  localparam int unsigned VoicesDefault  = 8;
  localparam int unsigned PitchW         = 7;
  localparam int unsigned VelW           = 7;
  localparam int unsigned VoiceIdxW      = 3;
  localparam int unsigned IncW           = 15;
  localparam int unsigned NumPitches     = 128;
  localparam int unsigned SemisPerOctave = 12;
  localparam int unsigned InTdataW       = 16;
  localparam int unsigned OutTdataW      = 24;

  // Per-semitone bases, 8.1757989156 * 2.048 * 2^(s/12), in units of 1e-12
  localparam logic [63:0] SemiBase [SemisPerOctave] = '{
    64'd16744036179149, 64'd17739688382425, 64'd18794545146613,
    64'd19912126958107, 64'd21096163642311, 64'd22350606811594,
    64'd23679643053419, 64'd25087707902698, 64'd26579500644974,
    64'd28159999999849, 64'd29834480736998, 64'd31608531280223
  };
  localparam logic [63:0] SemiUnit = 64'd1000000000000;
  localparam logic [63:0] SemiHalf = 64'd500000000000;

  typedef logic [IncW-1:0] inc_rom_t [NumPitches];

  // Evaluated at elaboration only
  function automatic inc_rom_t build_inc_rom();
    inc_rom_t    rom;
    int unsigned semi;
    int unsigned oct;
    logic [63:0] scaled;
    semi = 0;
    oct  = 0;
    for (int p = 0; p < NumPitches; p++) begin
      scaled = SemiBase[semi] << oct;
      rom[p] = IncW'((scaled + SemiHalf) / SemiUnit);
      if (semi == SemisPerOctave - 1) begin
        semi = 0;
        oct  = oct + 1;
      end else begin
        semi = semi + 1;
      end
    end
    return rom;
  endfunction

  localparam inc_rom_t IncRom = build_inc_rom();

  // Control from the sequencer to the voice table
  typedef struct packed {
    logic              note_on;
    logic              claim;
    logic              release_voice;
    logic [PitchW-1:0] pitch;
  } tbl_ctrl_t;

endpackage

### sv/mva_voice_table.sv
// ----------------------------------------------------------------------------
// MIDI voice allocator voice table
// Active flags and notes of all voices with one shared compare unit that
// tests the voice under the scan index each cycle.
// ----------------------------------------------------------------------------
module mva_voice_table #(
  parameter int unsigned VOICES = mva_pkg::VoicesDefault,
  parameter int unsigned IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mva_pkg::tbl_ctrl_t ctrl_i,
  input  logic [IDX_W-1:0]   idx_i,
  output logic               hit_o
);
  import mva_pkg::*;

  logic [VOICES-1:0] active_q;
  logic [PitchW-1:0] note_q [VOICES];

  // Free voice on note on, active voice holding the pitch on note off
  assign hit_o = ctrl_i.note_on ? !active_q[idx_i]
                                : (active_q[idx_i] && (note_q[idx_i] == ctrl_i.pitch));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (ctrl_i.claim) begin
      active_q[idx_i] <= 1'b1;
    end else if (ctrl_i.release_voice) begin
      active_q[idx_i] <= 1'b0;
    end
  end

  // Notes are only read behind a set active flag
  always_ff @(posedge clk_i) begin
    if (ctrl_i.claim) begin
      note_q[idx_i] <= ctrl_i.pitch;
    end
  end

endmodule

### sv/midi_voice_allocator_top.sv
// ----------------------------------------------------------------------------
// MIDI voice allocator
// Note events in, one oscillator write report out per event.
// ----------------------------------------------------------------------------
// Each event (pitch, velocity) is scanned against the voice table one voice
// per cycle through a single compare unit, stopping at the first hit: a note
// on claims the lowest free voice and reports its phase increment from the
// pitch ROM, a note off frees the lowest active voice holding that pitch and
// reports increment 0; if no voice qualifies the report has written = 0.
// The input is ready again once the report of an event sits in the output
// register, which holds it until the sink takes it.
module midi_voice_allocator_top #(
  parameter int unsigned VOICES = mva_pkg::VoicesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [6:0] pitch, [13:7] velocity
  input  logic [mva_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] written, [1] note_on, [4:2] voice_index, [19:5] phase_increment
  output logic [mva_pkg::OutTdataW-1:0] m_axis_tdata
);
  import mva_pkg::*;
  `include "midi_voice_allocator_top_defines.svh"

  localparam int unsigned IdxW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned LastIdx = VOICES - 1;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StHold = 3'b100
  } state_e;

  typedef struct packed {
    logic                 written;
    logic                 note_on;
    logic [VoiceIdxW-1:0] voice_index;
    logic [IncW-1:0]      phase_increment;
  } result_t;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [PitchW-1:0] pitch_q, pitch_d;
  logic              on_q, on_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              out_valid_q, out_valid_d;

  tbl_ctrl_t         ctrl;
  logic              hit;
  logic              last;
  logic              out_free;
  result_t           scan_res;

  mva_voice_table #(
    .VOICES (VOICES),
    .IDX_W  (IdxW)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .idx_i  (idx_q),
    .hit_o  (hit)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign last          = hit || (idx_q == IdxW'(LastIdx));

  always_comb begin
    ctrl.note_on       = on_q;
    ctrl.pitch         = pitch_q;
    ctrl.claim         = (state_q == StScan) && hit && on_q;
    ctrl.release_voice = (state_q == StScan) && hit && !on_q;

    scan_res.written         = hit;
    scan_res.note_on         = on_q;
    scan_res.voice_index     = hit ? VoiceIdxW'(idx_q) : '0;
    scan_res.phase_increment = (hit && on_q) ? IncRom[pitch_q] : '0;
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pitch_d     = pitch_q;
    on_d        = on_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          pitch_d = s_axis_tdata[PitchW-1:0];
          on_d    = (s_axis_tdata[PitchW +: VelW] != '0);
          idx_d   = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        if (last) begin
          if (out_free) begin
            out_d       = scan_res;
            out_valid_d = 1'b1;
            state_d     = StIdle;
          end else begin
            res_d   = scan_res;
            state_d = StHold;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StHold: begin
        // wait for the sink to drain the output register
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    pitch_q <= pitch_d;
    on_q    <= on_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_q.phase_increment, out_q.voice_index,
                          out_q.note_on, out_q.written};

  `MVA_ASSERT_NEXT(a_accept_starts_scan, s_axis_tvalid && s_axis_tready,
                   state_q == StScan, "accepted item did not start a scan")
  `MVA_ASSERT_NEXT(a_scan_advances, state_q == StScan && !last,
                   state_q == StScan && idx_q == IdxW'($past(idx_q) + 1'b1),
                   "scan index did not advance")
  `MVA_ASSERT_NOW(a_off_no_increment, out_valid_q && !out_q.note_on,
                  out_q.phase_increment == '0, "note off reported an increment")
  `MVA_ASSERT_NOW(a_miss_zero_voice, out_valid_q && !out_q.written,
                  out_q.voice_index == '0 && out_q.phase_increment == '0,
                  "miss reported a voice or increment")

endmodule
